// ===== rtl/fsd_pkg.sv =====
// ----------------------------------------------------------------------------
// fsd_pkg
// Types, constants and arithmetic helpers for the RGB error-diffusion dither.
// ----------------------------------------------------------------------------
package fsd_pkg;

  localparam int ERR_W      = 11;
  localparam int VAL_W      = 13;
  localparam int ERR_MAX    = 1023;
  localparam int ERR_MIN    = -1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int LANES      = 3;
  localparam int LINE_W     = LANES * ERR_W;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [2:0] W_UPPER_LEFT  = 3'd1;
  localparam logic [2:0] W_ABOVE       = 3'd5;
  localparam logic [2:0] W_UPPER_RIGHT = 3'd3;
  localparam logic [2:0] W_LEFT        = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL    = 2'd2;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic has_upper_left;
    logic has_above;
    logic has_upper_right;
  } up_flags_t;

  // add e*weight/16 to v, truncating toward zero
  function automatic val_t absorb(val_t v, err_t e, logic [2:0] weight);
    logic signed [17:0] s;
    logic signed [17:0] q;
    s = (18'(v) <<< 4) + 18'(e) * 18'($signed({1'b0, weight}));
    q = s >>> 4;
    if (s < 0 && s[3:0] != 4'd0) begin
      q = q + 18'sd1;
    end
    return val_t'(q);
  endfunction

  function automatic err_t sat_err(val_t d);
    err_t r;
    if (d > val_t'(ERR_MAX)) begin
      r = err_t'(ERR_MAX);
    end else if (d < val_t'(ERR_MIN)) begin
      r = err_t'(ERR_MIN);
    end else begin
      r = err_t'(d);
    end
    return r;
  endfunction

endpackage

// ===== rtl/fsd_line_mem.sv =====
// ----------------------------------------------------------------------------
// fsd_line_mem
// Error line store: one write port, two registered read ports, write-first.
// ----------------------------------------------------------------------------
module fsd_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 33
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr0,
  input  logic [$clog2(DEPTH)-1:0] rd_addr1,
  output logic [DATA_W-1:0]        rd_data0,
  output logic [DATA_W-1:0]        rd_data1
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= (wr_en && wr_addr == rd_addr0) ? wr_data : mem[rd_addr0];
      rd_data1 <= (wr_en && wr_addr == rd_addr1) ? wr_data : mem[rd_addr1];
    end
  end

endmodule

// ===== rtl/fsd_lane.sv =====
// ----------------------------------------------------------------------------
// fsd_lane
// One color channel: upper-row error intake, then left-error loop, threshold
// and fresh error.
// ----------------------------------------------------------------------------
module fsd_lane (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              a_valid,
  input  fsd_pkg::up_flags_t a_flags,
  input  logic [7:0]        a_pix,
  input  fsd_pkg::err_t     above_err,
  input  fsd_pkg::err_t     upper_right_err,
  input  logic              b_valid,
  input  logic              b_has_left,
  input  logic [7:0]        max_level,
  output logic [7:0]        level,
  output fsd_pkg::err_t     fresh
);

  fsd_pkg::err_t upper_left_err;
  fsd_pkg::err_t left_err;
  fsd_pkg::val_t vb;
  fsd_pkg::val_t v0, v1, v2, v3, v4;
  fsd_pkg::val_t thr_v, lvl_v, diff;
  logic          set;

  always_comb begin
    v0 = fsd_pkg::val_t'({5'b0, a_pix});
    v1 = a_flags.has_upper_left
       ? fsd_pkg::absorb(v0, upper_left_err, fsd_pkg::W_UPPER_LEFT) : v0;
    v2 = a_flags.has_above
       ? fsd_pkg::absorb(v1, above_err, fsd_pkg::W_ABOVE) : v1;
    v3 = a_flags.has_upper_right
       ? fsd_pkg::absorb(v2, upper_right_err, fsd_pkg::W_UPPER_RIGHT) : v2;
  end

  always_comb begin
    v4    = b_has_left ? fsd_pkg::absorb(vb, left_err, fsd_pkg::W_LEFT) : vb;
    thr_v = fsd_pkg::val_t'({6'b0, max_level[7:1]});
    lvl_v = fsd_pkg::val_t'({5'b0, max_level});
    set   = v4 > thr_v;
    level = set ? max_level : 8'd0;
    diff  = set ? v4 - lvl_v : v4;
    fresh = fsd_pkg::sat_err(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left_err <= '0;
      left_err       <= '0;
    end else if (advance) begin
      if (a_valid) begin
        upper_left_err <= above_err;
      end
      if (b_valid) begin
        left_err <= fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vb <= v3;
    end
  end

endmodule

// ===== rtl/floyd_steinberg_rgb_dither.sv =====
// ----------------------------------------------------------------------------
// floyd_steinberg_rgb_dither
// Floyd-Steinberg error-diffusion dither of an RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one raster-order pixel per clock and returns one dithered pixel per
// clock when the output side is not stalled and no pixel is held for the row
// above; frame_end marks the last pixel of each image_width x image_height
// frame. Three channel lanes run side by side; the previous row's errors come
// from a line memory of MAX_WIDTH entries with one write and two read ports,
// read as a pixel is taken and written back from stage b. Below the first row
// the pixel above may still be in flight for very narrow images: at an image
// width of one every such pixel is held while the one before it is in stage
// a, and at a width of two the first pixel of each such row is. Write
// configuration only while no pixel is in flight.
// ----------------------------------------------------------------------------
module floyd_steinberg_rgb_dither #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fsd_pkg::pixel_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fsd_pkg::pixel_out_t                out_data,
  input  logic                               cfg_write,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsd_pkg::CFG_W-1:0]          cfg_data
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = AW + 1;
  localparam int CMP_W = (WW > 11) ? WW : 11;
  localparam int RW    = $clog2(fsd_pkg::MAX_HEIGHT);
  localparam int HW    = RW + 1;

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [7:0]  max_level;

  logic [AW-1:0] column_count;
  logic [RW-1:0] row_count;

  logic [CMP_W-1:0] iw, weff_c;
  logic [WW-1:0]    weff, c1;
  logic [AW-1:0]    c;
  logic [HW-1:0]    heff, r1;
  logic [RW-1:0]    r;
  logic             col_last, row_last;
  logic             hazard, advance, accept;

  logic                a_valid;
  fsd_pkg::pixel_in_t  a_pix;
  fsd_pkg::up_flags_t  a_flags;
  logic                a_has_left;
  logic                a_last;
  logic [AW-1:0]       a_col;

  logic          b_valid;
  logic          b_has_left;
  logic          b_last;
  logic [AW-1:0] b_col;

  fsd_pkg::up_flags_t        up_flags;
  logic [fsd_pkg::LINE_W-1:0] above_line, upper_right_line, fresh_line;
  logic [7:0]                 lvl [fsd_pkg::LANES];
  fsd_pkg::err_t              fresh [fsd_pkg::LANES];
  logic [7:0]                 pix [fsd_pkg::LANES];

  always_comb begin
    iw     = CMP_W'(image_width);
    weff_c = iw;
    if (iw == '0) begin
      weff_c = CMP_W'(1);
    end else if (iw > CMP_W'(MAX_WIDTH)) begin
      weff_c = CMP_W'(MAX_WIDTH);
    end
    weff     = WW'(weff_c);
    c        = (WW'(column_count) < weff) ? column_count : AW'(weff - WW'(1));
    c1       = WW'(c) + WW'(1);
    col_last = c1 >= weff;

    heff = image_height;
    if (image_height == '0) begin
      heff = HW'(1);
    end else if (image_height > HW'(fsd_pkg::MAX_HEIGHT)) begin
      heff = HW'(fsd_pkg::MAX_HEIGHT);
    end
    r        = (HW'(row_count) < heff) ? row_count : RW'(heff - HW'(1));
    r1       = HW'(r) + HW'(1);
    row_last = r1 >= heff;

    up_flags.has_upper_left  = (r != '0) && (c != '0);
    up_flags.has_above       = (r != '0);
    up_flags.has_upper_right = (r != '0) && !col_last;
  end

  assign hazard   = a_valid && (r != '0)
                  && (a_col == c || (!col_last && a_col == AW'(c1)));
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && !hazard;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
      max_level    <= 8'd255;
    end else if (cfg_write) begin
      case (cfg_index)
        fsd_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        fsd_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        fsd_pkg::CFG_MAX_LEVEL:    max_level    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        if (col_last) begin
          column_count <= '0;
          row_count    <= row_last ? '0 : RW'(r1);
        end else begin
          column_count <= AW'(c1);
          row_count    <= r;
        end
      end
      if (advance) begin
        a_valid   <= accept;
        b_valid   <= a_valid;
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_pix      <= in_data;
      a_flags    <= up_flags;
      a_has_left <= (c != '0);
      a_last     <= col_last && row_last;
      a_col      <= c;
      b_has_left <= a_has_left;
      b_last     <= a_last;
      b_col      <= a_col;
      out_data.red_out   <= lvl[0];
      out_data.green_out <= lvl[1];
      out_data.blue_out  <= lvl[2];
      out_data.frame_end <= b_last;
    end
  end

  fsd_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (fsd_pkg::LINE_W)
  ) u_line (
    .clk      (clk),
    .wr_en    (b_valid && advance),
    .wr_addr  (b_col),
    .wr_data  (fresh_line),
    .rd_en    (accept),
    .rd_addr0 (c),
    .rd_addr1 (AW'(c1)),
    .rd_data0 (above_line),
    .rd_data1 (upper_right_line)
  );

  assign pix[0] = a_pix.red_in;
  assign pix[1] = a_pix.green_in;
  assign pix[2] = a_pix.blue_in;

  for (genvar g = 0; g < fsd_pkg::LANES; g++) begin : g_lane
    fsd_lane u_lane (
      .clk             (clk),
      .rst             (rst),
      .advance         (advance),
      .a_valid         (a_valid),
      .a_flags         (a_flags),
      .a_pix           (pix[g]),
      .above_err       (fsd_pkg::err_t'(above_line[g*fsd_pkg::ERR_W +: fsd_pkg::ERR_W])),
      .upper_right_err (fsd_pkg::err_t'(
                          upper_right_line[g*fsd_pkg::ERR_W +: fsd_pkg::ERR_W])),
      .b_valid         (b_valid),
      .b_has_left      (b_has_left),
      .max_level       (max_level),
      .level           (lvl[g]),
      .fresh           (fresh[g])
    );
    assign fresh_line[g*fsd_pkg::ERR_W +: fsd_pkg::ERR_W] = fresh[g];
  end

endmodule
